// ----- src/fcls_pkg.sv -----
// ----------------------------------------------------------------------------
// fcls_pkg
// Shared constants, codes and types of the flash config log store.
// ----------------------------------------------------------------------------
package fcls_pkg;

	localparam int unsigned REGION_WORDS_DEF = 1024;
	localparam int unsigned WORD_W           = 32;
	localparam int unsigned IDX_W            = 10;
	localparam int unsigned BYTES_W          = 12;
	localparam int unsigned IN_TDATA_W       = 48;
	localparam int unsigned IN_TUSER_W       = 3;
	localparam int unsigned OUT_TDATA_W      = 16;
	localparam int unsigned OUT_TUSER_W      = 2;

	localparam logic [WORD_W-1:0] ERASED_WORD     = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] TERMINATOR_WORD = 32'h000A_0D20;
	localparam logic [WORD_W-1:0] MARKER_RESET    = 32'h3A67_6663;

	typedef enum logic [1:0] {
		REQ_LOCATE = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_ERASE  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NOTFOUND = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} store_cmd_t;

endpackage

// ----- src/flash_config_log_store.sv -----
// ----------------------------------------------------------------------------
// flash_config_log_store
// Append-only word log over an erased-flash style store with locate,
// append and erase requests, run by a sequencer around one shared compare.
// Throughput: one item at a time; the next item is taken once the result is
//   loaded into the output register. All steps share one store port.
// Reset: a clearing pass fills the store with ones; erase requests and an
//   overflowing first word run the same pass.
// ----------------------------------------------------------------------------
module flash_config_log_store #(
	parameter int unsigned REGION_WORDS = fcls_pkg::REGION_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [fcls_pkg::WORD_W-1:0]    cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// data_word [31:0], record_bytes [43:32], zero [47:44]
	input  logic [fcls_pkg::IN_TDATA_W-1:0]  s_tdata,
	// req_type [1:0], first_word [2]
	input  logic [fcls_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// word_index [9:0], zero [15:10]
	output logic [fcls_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status [1:0]
	output logic [fcls_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import fcls_pkg::*;

	localparam int unsigned AW  = $clog2(REGION_WORDS);
	localparam int unsigned PW  = AW + 1;
	localparam int unsigned XW  = AW + IDX_W;
	localparam int unsigned SW  = ((AW + 2) > BYTES_W ? (AW + 2) : BYTES_W) + 1;
	localparam logic [AW-1:0] LAST_IDX  = AW'(REGION_WORDS - 1);
	localparam logic [PW-1:0] PTR_END   = PW'(REGION_WORDS);
	localparam logic [SW-1:0] BYTE_LIM  = SW'(4 * (REGION_WORDS - 1));

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_CLEAR  = 11'b000_0000_0010,
		ST_CHK0   = 11'b000_0000_0100,
		ST_SRCH   = 11'b000_0000_1000,
		ST_SCHK   = 11'b000_0001_0000,
		ST_SCAN   = 11'b000_0010_0000,
		ST_SCMP   = 11'b000_0100_0000,
		ST_WMARK  = 11'b000_1000_0000,
		ST_WTERM  = 11'b001_0000_0000,
		ST_APPEND = 11'b010_0000_0000,
		ST_RESP   = 11'b100_0000_0000
	} state_t;

	state_t            st_q;
	req_t              req_q;
	logic [WORD_W-1:0] data_q;
	logic [BYTES_W-1:0] bytes_q;
	logic              busy_q;
	logic [WORD_W-1:0] marker_q;
	logic [AW-1:0]     lo_q, hi_q, mid_q, clr_cnt_q;
	logic [PW-1:0]     ptr_q;
	status_t           res_status_q;
	logic [IDX_W-1:0]  res_index_q;
	logic              m_tvalid_q;
	status_t           m_status_q;
	logic [IDX_W-1:0]  m_index_q;

	logic              accept;
	req_t              in_req;
	logic              in_first;
	store_cmd_t        cmd;
	logic [AW-1:0]     addr;
	logic [WORD_W-1:0] wdata, rdata, cmp_ref;
	logic              eq;
	logic [AW-1:0]     span, mid_c, idx_src;
	logic              span_gt1;
	logic [SW-1:0]     need;
	logic              full;
	logic [XW-1:0]     idx_ext;
	logic              out_free;

	assign in_req   = req_t'(s_tuser[1:0]);
	assign in_first = s_tuser[2];
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign span     = hi_q - lo_q;
	assign span_gt1 = span > AW'(1);
	assign mid_c    = lo_q + (span >> 1);
	assign need     = SW'({hi_q, 2'b00}) + SW'(bytes_q);
	assign full     = ptr_q >= PTR_END;
	assign out_free = !m_tvalid_q || m_tready;

	assign cmp_ref = (st_q == ST_SCMP) ? marker_q : ERASED_WORD;
	assign eq      = (rdata == cmp_ref);

	assign idx_src = (st_q == ST_SCMP) ? lo_q : ptr_q[AW-1:0];
	assign idx_ext = XW'(idx_src);

	always_comb begin
		cmd   = '0;
		addr  = '0;
		wdata = ERASED_WORD;
		case (st_q)
			ST_IDLE: begin
				cmd.rd = accept && ((in_req == REQ_LOCATE) ||
					((in_req == REQ_APPEND) && in_first));
			end
			ST_CLEAR: begin
				cmd.wr = 1'b1;
				addr   = clr_cnt_q;
			end
			ST_SRCH: begin
				cmd.rd = span_gt1;
				addr   = mid_c;
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				addr   = lo_q;
			end
			ST_WMARK: begin
				cmd.wr = 1'b1;
				wdata  = marker_q;
			end
			ST_WTERM: begin
				cmd.wr = 1'b1;
				addr   = AW'(1);
				wdata  = TERMINATOR_WORD;
			end
			ST_APPEND: begin
				cmd.wr = !full;
				addr   = ptr_q[AW-1:0];
				wdata  = data_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	fcls_store #(
		.DEPTH (REGION_WORDS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.cmd   (cmd),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_wen) begin
			marker_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= in_req;
			data_q  <= s_tdata[WORD_W-1:0];
			bytes_q <= s_tdata[WORD_W+BYTES_W-1:WORD_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			busy_q       <= 1'b0;
			clr_cnt_q    <= '0;
			ptr_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			res_status_q <= STATUS_OK;
			res_index_q  <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						busy_q       <= 1'b1;
						res_status_q <= STATUS_OK;
						res_index_q  <= '0;
						case (in_req)
							REQ_LOCATE: st_q <= ST_CHK0;
							REQ_APPEND: st_q <= in_first ? ST_CHK0 : ST_APPEND;
							REQ_ERASE: begin
								ptr_q <= '0;
								st_q  <= ST_CLEAR;
							end
							default: st_q <= ST_RESP;
						endcase
					end
				end
				ST_CLEAR: begin
					if (clr_cnt_q == LAST_IDX) begin
						clr_cnt_q <= '0;
						if (!busy_q) begin
							st_q <= ST_IDLE;
						end else if (req_q == REQ_APPEND) begin
							ptr_q <= '0;
							st_q  <= ST_APPEND;
						end else begin
							st_q <= ST_RESP;
						end
					end else begin
						clr_cnt_q <= clr_cnt_q + AW'(1);
					end
				end
				ST_CHK0: begin
					lo_q <= '0;
					hi_q <= LAST_IDX;
					if (!eq) begin
						st_q <= ST_SRCH;
					end else if (req_q == REQ_LOCATE) begin
						st_q <= ST_WMARK;
					end else begin
						ptr_q <= '0;
						st_q  <= ST_APPEND;
					end
				end
				ST_SRCH: begin
					if (span_gt1) begin
						mid_q <= mid_c;
						st_q  <= ST_SCHK;
					end else if (req_q == REQ_LOCATE) begin
						st_q <= ST_SCAN;
					end else if (need > BYTE_LIM) begin
						st_q <= ST_CLEAR;
					end else begin
						ptr_q <= PW'(hi_q);
						st_q  <= ST_APPEND;
					end
				end
				ST_SCHK: begin
					if (eq) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q;
					end
					st_q <= ST_SRCH;
				end
				ST_SCAN: begin
					st_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (eq) begin
						res_index_q <= idx_ext[IDX_W-1:0];
						st_q        <= ST_RESP;
					end else if (lo_q == '0) begin
						res_status_q <= STATUS_NOTFOUND;
						st_q         <= ST_RESP;
					end else begin
						lo_q <= lo_q - AW'(1);
						st_q <= ST_SCAN;
					end
				end
				ST_WMARK: begin
					st_q <= ST_WTERM;
				end
				ST_WTERM: begin
					st_q <= ST_RESP;
				end
				ST_APPEND: begin
					if (full) begin
						ptr_q        <= PTR_END;
						res_status_q <= STATUS_FULL;
					end else begin
						res_index_q <= idx_ext[IDX_W-1:0];
						ptr_q       <= ptr_q + PW'(1);
					end
					st_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						busy_q <= 1'b0;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((st_q == ST_RESP) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_RESP) && out_free) begin
			m_status_q <= res_status_q;
			m_index_q  <= res_index_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(m_index_q);
	assign m_tuser  = m_status_q;

endmodule

// ----- src/fcls_store.sv -----
// ----------------------------------------------------------------------------
// fcls_store
// Single-port word store with registered read data.
// ----------------------------------------------------------------------------
module fcls_store #(
	parameter int unsigned DEPTH = fcls_pkg::REGION_WORDS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  fcls_pkg::store_cmd_t       cmd,
	input  logic [AW-1:0]              addr,
	input  logic [fcls_pkg::WORD_W-1:0] wdata,
	output logic [fcls_pkg::WORD_W-1:0] rdata
);
	import fcls_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sim/flash_config_log_store_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_config_log_store_tb
// Drives locate, append, erase and spare-code requests into the log store.
// Each accepted request goes through an in-bench image of the store, and each
// status and word index that comes out is checked in order against it. The
// phases cover the empty store, the marker search, the overflow erase, a
// long record scanned back from its end, and random record traffic under
// several marker values. Both stream sides idle at random outside one phase.
// ----------------------------------------------------------------------------
module flash_config_log_store_tb;
	import fcls_pkg::*;

	localparam int unsigned REGION = REGION_WORDS_DEF;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 2200;

	typedef struct packed {
		logic [1:0]  req;
		logic        first;
		logic [11:0] bytes;
		logic [31:0] data;
	} log_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] index;
	} log_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wen = 1'b0;
	logic [WORD_W-1:0]      cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;

	log_req_t    request_q[$];
	log_result_t outcome_q[$];
	log_req_t    drv_item;

	logic [31:0] flash_img [REGION];
	int unsigned wr_ptr;
	logic [31:0] marker_now;

	int idle_pct = 14;
	int err_count = 0;
	int n_locate = 0;
	int n_append = 0;
	int n_erase = 0;
	int n_spare = 0;
	int n_checked = 0;
	int n_full = 0;
	int n_missing = 0;

	flash_config_log_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic void clear_image();
		for (int i = 0; i < REGION; i++)
			flash_img[i] = ERASED_WORD;
	endfunction

	function automatic void find_end(output int unsigned lo, output int unsigned hi);
		int unsigned mid;
		lo = 0;
		hi = REGION - 1;
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			if (flash_img[mid] == ERASED_WORD)
				hi = mid;
			else
				lo = mid;
		end
	endfunction

	function automatic log_result_t store_outcome(log_req_t r);
		log_result_t res;
		int unsigned lo;
		int unsigned hi;
		int k;
		bit found;
		res.status = STATUS_OK;
		res.index = '0;
		case (r.req)
			REQ_LOCATE: begin
				if (flash_img[0] == ERASED_WORD) begin
					flash_img[0] = marker_now;
					flash_img[1] = TERMINATOR_WORD;
				end else begin
					find_end(lo, hi);
					found = 1'b0;
					k = int'(lo);
					while (!found && k >= 0) begin
						if (flash_img[k] == marker_now) begin
							found = 1'b1;
							res.index = 10'(k);
						end
						k--;
					end
					if (!found)
						res.status = STATUS_NOTFOUND;
				end
			end
			REQ_APPEND: begin
				if (r.first) begin
					if (flash_img[0] == ERASED_WORD) begin
						wr_ptr = 0;
					end else begin
						find_end(lo, hi);
						if (4 * hi + r.bytes > 4 * (REGION - 1)) begin
							clear_image();
							wr_ptr = 0;
						end else begin
							wr_ptr = hi;
						end
					end
				end
				if (wr_ptr >= REGION) begin
					wr_ptr = REGION;
					res.status = STATUS_FULL;
				end else begin
					flash_img[wr_ptr] = r.data;
					res.index = 10'(wr_ptr);
					wr_ptr++;
				end
			end
			REQ_ERASE: begin
				clear_image();
				wr_ptr = 0;
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(store_outcome(drv_item));
				case (drv_item.req)
					REQ_LOCATE: n_locate++;
					REQ_APPEND: n_append++;
					REQ_ERASE:  n_erase++;
					default:    n_spare++;
				endcase
			end
			if (!s_tvalid || s_tready) begin
				if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					drv_item = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, drv_item.bytes, drv_item.data};
					s_tuser <= {drv_item.first, drv_item.req};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		log_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$error("result with nothing expected: status %0d, word_index %0d",
						m_tuser, m_tdata[IDX_W-1:0]);
					err_count++;
				end else begin
					want = outcome_q.pop_front();
					n_checked++;
					if (want.status == STATUS_FULL)
						n_full++;
					if (want.status == STATUS_NOTFOUND)
						n_missing++;
					if (m_tuser[1:0] !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, m_tuser[1:0]);
						err_count++;
					end
					if (m_tdata[IDX_W-1:0] !== want.index) begin
						$error("word_index mismatch: expected %0d, actual %0d",
							want.index, m_tdata[IDX_W-1:0]);
						err_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic push_item(logic [1:0] req, logic [31:0] data, logic [11:0] bytes,
		logic first);
		log_req_t r;
		r.req = req;
		r.data = data;
		r.bytes = bytes;
		r.first = first;
		request_q.push_back(r);
	endtask

	function automatic logic [31:0] rand_payload();
		case ($urandom_range(9))
			0: return marker_now;
			1: return ERASED_WORD;
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_record(int unsigned words, logic [11:0] bytes);
		push_item(REQ_APPEND, marker_now, bytes, 1'b1);
		for (int unsigned i = 1; i < words; i++)
			push_item(REQ_APPEND, rand_payload(), 12'($urandom_range(4095)), 1'b0);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
	endtask

	task automatic write_marker(logic [31:0] value);
		wait_drained();
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		marker_now = value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_traffic(int budget);
		int unsigned words;
		int pick;
		logic [1:0] req;
		logic [11:0] bytes;
		while (budget > 0) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				words = $urandom_range(1, 8);
				bytes = ($urandom_range(19) == 0) ? 12'($urandom_range(4095))
					: 12'(4 * words);
				push_record(words, bytes);
				budget -= words;
				if ($urandom_range(1)) begin
					push_item(REQ_LOCATE, $urandom, 12'($urandom_range(4095)), 1'($urandom));
					budget--;
				end
			end else if (pick < 70) begin
				push_item(REQ_LOCATE, $urandom, 12'($urandom_range(4095)), 1'($urandom));
				budget--;
			end else if (pick < 78) begin
				push_item(REQ_APPEND, rand_payload(), 12'($urandom_range(4095)), 1'b0);
				budget--;
			end else if (pick < 84) begin
				push_item(REQ_APPEND, rand_payload(), 12'($urandom_range(64)), 1'b1);
				budget--;
			end else if (pick < 88) begin
				push_item(REQ_ERASE, $urandom, 12'($urandom_range(4095)), 1'($urandom));
				budget--;
			end else if (pick < 93) begin
				push_item(REQ_SPARE, $urandom, 12'($urandom_range(4095)), 1'($urandom));
			end else begin
				req = 2'($urandom_range(3));
				push_item(req, $urandom, 12'($urandom_range(4095)), 1'($urandom));
				if (req != REQ_SPARE)
					budget--;
			end
		end
		wait_drained();
	endtask

	initial begin
		clear_image();
		wr_ptr = 0;
		marker_now = MARKER_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(REQ_LOCATE, '0, '0, 1'b0);
		push_item(REQ_LOCATE, ERASED_WORD, 12'hFFF, 1'b1);
		push_item(REQ_APPEND, '0, 12'd0, 1'b1);
		push_item(REQ_APPEND, ERASED_WORD, 12'hFFF, 1'b0);
		push_item(REQ_APPEND, marker_now, 12'd8, 1'b1);
		push_item(REQ_APPEND, 32'h1234_5678, 12'd0, 1'b0);
		push_item(REQ_LOCATE, '0, '0, 1'b0);
		push_item(REQ_ERASE, '0, '0, 1'b0);
		push_item(REQ_APPEND, 32'hA5A5_A5A5, 12'd4, 1'b0);
		push_item(REQ_LOCATE, '0, '0, 1'b0);
		push_item(REQ_APPEND, marker_now, 12'hFFF, 1'b1);
		push_item(REQ_LOCATE, '0, '0, 1'b0);
		push_item(REQ_SPARE, ERASED_WORD, 12'hFFF, 1'b1);
		push_item(REQ_ERASE, ERASED_WORD, 12'hFFF, 1'b1);
		push_item(REQ_APPEND, marker_now, 12'd4, 1'b1);
		push_item(REQ_LOCATE, '0, '0, 1'b0);

		write_marker($urandom);
		push_item(REQ_ERASE, '0, '0, 1'b0);
		push_record(48, 12'd192);
		repeat (3)
			push_item(REQ_APPEND, $urandom, '0, 1'b0);
		push_item(REQ_LOCATE, '0, '0, 1'b0);
		push_item(REQ_APPEND, marker_now, 12'd4092, 1'b1);
		push_item(REQ_APPEND, $urandom, '0, 1'b0);
		push_item(REQ_APPEND, marker_now, 12'd4, 1'b1);
		push_item(REQ_LOCATE, '0, '0, 1'b0);

		write_marker('0);
		random_traffic(100);
		write_marker(ERASED_WORD);
		random_traffic(80);
		write_marker(MARKER_RESET);
		idle_pct = 0;
		random_traffic(80);
		idle_pct = 14;
		write_marker($urandom);
		random_traffic(70);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outcome_q.size() != 0) begin
			$error("%0d results never arrived", outcome_q.size());
			err_count++;
		end
		$display("covered %0d locate, %0d append, %0d erase and %0d spare-code requests",
			n_locate, n_append, n_erase, n_spare);
		$display("checked %0d results, %0d marker misses, %0d words dropped on a full store",
			n_checked, n_missing, n_full);
		if (err_count == 0)
			$display("flash_config_log_store_tb OK");
		else
			$display("flash_config_log_store_tb NOT OK");
		$finish;
	end

	initial begin
		#(60_000_000);
		$display("flash_config_log_store_tb NOT OK");
		$finish;
	end

endmodule
